@@ src/fssm_pkg.sv @@
`timescale 1ns / 1ps

package fssm_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned IdxW     = 5;
  localparam int unsigned CfgW     = 6;
  localparam int unsigned PosW     = 20;
  localparam logic [PosW-1:0] PosMax = '1;

  localparam int unsigned MaxPatternDefault = 32;
  localparam int unsigned MaxTextDefault    = 1048576;

  typedef enum logic [ModeW-1:0] {
    ModeLoad = 2'd0,
    ModeText = 2'd1,
    ModeEnd  = 2'd2
  } mode_e;

endpackage

@@ src/fssm_in_if.sv @@
`timescale 1ns / 1ps

interface fssm_in_if import fssm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ModeW-1:0] mode;
  logic [IdxW-1:0]  pattern_index;
  logic [ByteW-1:0] data_byte;

  modport source (output valid, mode, pattern_index, data_byte, input ready);
  modport sink   (input valid, mode, pattern_index, data_byte, output ready);
endinterface

@@ src/fssm_out_if.sv @@
`timescale 1ns / 1ps

interface fssm_out_if import fssm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            found;
  logic [PosW-1:0] match_position;

  modport source (output valid, found, match_position, input ready);
  modport sink   (input valid, found, match_position, output ready);
endinterface

@@ src/fssm_cfg_if.sv @@
`timescale 1ns / 1ps

interface fssm_cfg_if import fssm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CfgW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ src/fssm_match.sv @@
`timescale 1ns / 1ps

// Compares the newest len_i window bytes with the first len_i pattern bytes.
// Window entry 0 is the newest byte, so pattern byte j pairs with entry len_i-1-j.
module fssm_match import fssm_pkg::*; #(
  parameter int unsigned MaxPattern = MaxPatternDefault,
  parameter int unsigned LenW       = $clog2(MaxPattern + 1)
) (
  input  logic [ByteW-1:0] win_i [MaxPattern],
  input  logic [ByteW-1:0] pat_i [MaxPattern],
  input  logic [LenW-1:0]  len_i,
  output logic             match_o
);

  logic [ByteW-1:0]      sel_c [MaxPattern];
  logic [MaxPattern-1:0] hit_c;

  always_comb begin
    for (int j = 0; j < MaxPattern; j++) begin
      sel_c[j] = '0;
      for (int k = 0; k < MaxPattern; k++) begin
        if (k == int'(len_i) - 1 - j) begin
          sel_c[j] = win_i[k];
        end
      end
      hit_c[j] = (j >= int'(len_i)) || (sel_c[j] == pat_i[j]);
    end
  end

  assign match_o = &hit_c;

endmodule

@@ src/first_substring_match_search.sv @@
`timescale 1ns / 1ps

// Channel  Dir  Payload                               Transfer
// in_i     in   mode, pattern_index, data_byte        valid & ready
// cfg_i    in   data = pattern_length                 valid & ready
// out_o    out  found, match_position                 valid & ready
//
// One item per cycle while in_i.ready is high; load, text and end items update the state
// as they are taken (text past MaxText is dropped), and an end item registers its answer.
// The window comparators work on the window plus the incoming byte in that cycle.
// in_i.ready drops only while a result waits and out_o.ready is low; cfg_i is always ready.
// Reset clears the counters, the match flag, the length and the result valid flag;
// the pattern store holds whatever was loaded.
module first_substring_match_search import fssm_pkg::*; #(
  parameter int unsigned MaxPattern = MaxPatternDefault,
  parameter int unsigned MaxText    = MaxTextDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fssm_in_if.sink     in_i,
  fssm_cfg_if.sink    cfg_i,
  fssm_out_if.source  out_o
);

  localparam int unsigned LenW = $clog2(MaxPattern + 1);
  localparam int unsigned CntW = $clog2(MaxText + 1);

  logic [CfgW-1:0]  cfg_len_q;
  logic [LenW-1:0]  len_c;
  logic [CntW-1:0]  len_ext_c;

  logic [ByteW-1:0] pat_q   [MaxPattern];
  logic [ByteW-1:0] win_q   [MaxPattern];
  logic [ByteW-1:0] win_d   [MaxPattern];

  logic [CntW-1:0]  count_q, count_d, count_inc_c, start_c;
  logic             seen_q, seen_d;
  logic [PosW-1:0]  first_q, first_d;

  logic             out_valid_q, out_valid_d;
  logic             found_q, found_d;
  logic [PosW-1:0]  pos_q, pos_d;

  logic             in_xfer_c, is_load_c, is_text_c, is_end_c, text_ok_c;
  logic             win_match_c;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q <= '0;
    end else if (cfg_i.valid) begin
      cfg_len_q <= cfg_i.data;
    end
  end

  // lengths above the store depth act as the full depth
  assign len_c     = (32'(cfg_len_q) > 32'(MaxPattern)) ? LenW'(MaxPattern) : LenW'(cfg_len_q);
  assign len_ext_c = CntW'(len_c);

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_xfer_c  = in_i.valid && in_i.ready;

  always_comb begin
    is_load_c = 1'b0;
    is_text_c = 1'b0;
    is_end_c  = 1'b0;
    case (mode_e'(in_i.mode))
      ModeLoad: is_load_c = in_xfer_c;
      ModeText: is_text_c = in_xfer_c;
      ModeEnd:  is_end_c  = in_xfer_c;
      default: ;
    endcase
  end

  // pattern store: one register per entry, indexes past the depth fall away
  for (genvar g = 0; g < MaxPattern; g++) begin : g_pat
    always_ff @(posedge clk_i) begin
      if (is_load_c && (32'(in_i.pattern_index) == g)) begin
        pat_q[g] <= in_i.data_byte;
      end
    end
  end

  always_comb begin
    win_d[0] = in_i.data_byte;
    for (int k = 1; k < MaxPattern; k++) begin
      win_d[k] = win_q[k-1];
    end
  end

  fssm_match #(
    .MaxPattern (MaxPattern),
    .LenW       (LenW)
  ) u_match (
    .win_i   (win_d),
    .pat_i   (pat_q),
    .len_i   (len_c),
    .match_o (win_match_c)
  );

  assign text_ok_c   = count_q < CntW'(MaxText);
  assign count_inc_c = count_q + CntW'(1);
  assign start_c     = count_inc_c - len_ext_c;

  always_comb begin
    count_d = count_q;
    seen_d  = seen_q;
    first_d = first_q;
    if (is_text_c && text_ok_c) begin
      count_d = count_inc_c;
      if (!seen_q && (len_c != '0) && (count_inc_c >= len_ext_c) && win_match_c
          && (32'(start_c) <= 32'(PosMax))) begin
        seen_d  = 1'b1;
        first_d = PosW'(start_c);
      end
    end else if (is_end_c) begin
      count_d = '0;
      seen_d  = 1'b0;
      first_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      seen_q  <= 1'b0;
      first_q <= '0;
    end else begin
      count_q <= count_d;
      seen_q  <= seen_d;
      first_q <= first_d;
    end
  end

  // window contents past the byte count are never compared, so no reset
  always_ff @(posedge clk_i) begin
    if (is_text_c && text_ok_c) begin
      win_q <= win_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    found_d     = found_q;
    pos_d       = pos_q;
    if (is_end_c) begin
      out_valid_d = 1'b1;
      found_d     = (len_c == '0) || seen_q;
      pos_d       = ((len_c != '0) && seen_q) ? first_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    pos_q   <= pos_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.found          = found_q;
  assign out_o.match_position = pos_q;

endmodule
